FILE: design/wbp_pkg.sv
// Package for the wildcard byte pattern patcher.
// Holds the payload structs and the configuration register indexes.
// No dependencies.
package wbp_pkg;

  localparam int BYTE_W       = 8;
  localparam int CFG_ADDR_W   = 3;
  localparam int CFG_DATA_W   = 64;
  localparam int PLEN_W       = 5;
  localparam int RLEN_W       = 4;
  localparam logic [PLEN_W-1:0] PLEN_RST     = PLEN_W'(1);
  localparam logic [BYTE_W-1:0] WILDCARD_RST = 8'h2A;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_PATTERN_LOW  = 3'd0,
    CFG_PATTERN_HIGH = 3'd1,
    CFG_PATTERN_LEN  = 3'd2,
    CFG_REPLACEMENT  = 3'd3,
    CFG_REPLACE_LEN  = 3'd4,
    CFG_WILDCARD     = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              match_start;
    logic              out_last;
  } out_item_t;

endpackage

FILE: design/wildcard_byte_pattern_patcher.sv
// Wildcard byte pattern patcher: sliding window compare and in-place replacement.
// Uses wbp_pkg for payload structs and register indexes.
//
// The block takes one byte per cycle and gives one byte per cycle once the window
// holds pattern_len bytes, unless out_stall or a drain holds it. At the earliest a
// byte passes through the input register, then the result register. The window
// compare, patch and shift are done together in the same cycle. Bytes left in the
// window at end of stream, and bytes beyond a lowered pattern_len, leave from the
// window head one per cycle while the input is stalled, unless out_stall holds them.
module wildcard_byte_pattern_patcher #(
  parameter int MAX_PATTERN = 16,
  parameter int MAX_REPLACE = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [wbp_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [wbp_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  wbp_pkg::in_item_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output wbp_pkg::out_item_t                  out_data
);

  localparam int FILL_W = $clog2(MAX_PATTERN + 1);
  localparam logic [wbp_pkg::PLEN_W-1:0] MAXP = wbp_pkg::PLEN_W'(MAX_PATTERN);
  localparam logic [wbp_pkg::RLEN_W-1:0] MAXR = wbp_pkg::RLEN_W'(MAX_REPLACE);

  logic [63:0]                      pattern_low_r;
  logic [63:0]                      pattern_high_r;
  logic [wbp_pkg::PLEN_W-1:0]       pattern_len_r;
  logic [63:0]                      replacement_r;
  logic [wbp_pkg::RLEN_W-1:0]       replace_len_r;
  logic [wbp_pkg::BYTE_W-1:0]       wildcard_r;

  wbp_pkg::in_item_t                in_r;
  logic                             in_full_r;
  logic                             in_full_nxt;
  logic [wbp_pkg::BYTE_W-1:0]       orig_r    [MAX_PATTERN];
  logic [wbp_pkg::BYTE_W-1:0]       patched_r [MAX_PATTERN];
  logic [wbp_pkg::BYTE_W-1:0]       orig_nxt    [MAX_PATTERN];
  logic [wbp_pkg::BYTE_W-1:0]       patched_nxt [MAX_PATTERN];
  logic [wbp_pkg::BYTE_W-1:0]       app_orig    [MAX_PATTERN];
  logic [wbp_pkg::BYTE_W-1:0]       app_patched [MAX_PATTERN];
  logic [FILL_W-1:0]                fill_r;
  logic [FILL_W-1:0]                fill_nxt;
  logic                             busy_r;
  logic                             busy_nxt;
  logic                             flush_r;
  logic                             flush_nxt;
  wbp_pkg::out_item_t               out_r;
  wbp_pkg::out_item_t               out_nxt;
  logic                             out_valid_r;
  logic                             out_valid_nxt;

  logic                             out_free;
  logic                             consume;
  logic                             op_go;
  logic [wbp_pkg::PLEN_W-1:0]       plen5;
  logic [FILL_W-1:0]                plen;
  logic [wbp_pkg::RLEN_W-1:0]       rlen;
  logic [FILL_W-1:0]                f_src;
  logic [FILL_W-1:0]                f_after;
  logic                             last_src;
  logic                             pat_ok;
  logic                             hit;
  logic                             emit;
  logic [127:0]                     pat_all;
  logic [wbp_pkg::BYTE_W-1:0]       pat_b;
  logic [wbp_pkg::BYTE_W-1:0]       next_p;

  always_comb begin
    plen5 = pattern_len_r;
    if (plen5 == '0) begin
      plen5 = wbp_pkg::PLEN_W'(1);
    end else if (plen5 > MAXP) begin
      plen5 = MAXP;
    end
    plen = FILL_W'(plen5);
    rlen = replace_len_r;
    if (rlen > MAXR) begin
      rlen = MAXR;
    end
    if ({1'b0, rlen} > plen5) begin
      rlen = wbp_pkg::RLEN_W'(plen5);
    end
  end

  assign out_free = !out_valid_r || !out_stall;
  assign consume  = in_full_r && !busy_r && out_free;
  assign op_go    = consume || (busy_r && out_free);
  assign in_stall = in_full_r && !consume;
  assign pat_all  = {pattern_high_r, pattern_low_r};

  always_comb begin
    for (int i = 0; i < MAX_PATTERN; i++) begin
      app_orig[i]    = (consume && FILL_W'(i) == fill_r) ? in_r.data_byte : orig_r[i];
      app_patched[i] = (consume && FILL_W'(i) == fill_r) ? in_r.data_byte : patched_r[i];
    end
    f_src    = consume ? fill_r + FILL_W'(1) : fill_r;
    last_src = consume ? in_r.end_of_stream : flush_r;

    pat_ok = 1'b1;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      pat_b = pat_all[8*i +: 8];
      if (FILL_W'(i) < plen && pat_b != wildcard_r && pat_b != app_orig[i]) begin
        pat_ok = 1'b0;
      end
    end
    hit  = op_go && (f_src == plen) && pat_ok;
    emit = op_go && ((f_src >= plen) || (last_src && f_src != '0));
    f_after = emit ? f_src - FILL_W'(1) : f_src;

    for (int i = 0; i < MAX_PATTERN; i++) begin
      next_p = (i + 1 < MAX_PATTERN) ? app_patched[(i + 1) % MAX_PATTERN] : '0;
      if (hit && (i + 1) < int'(rlen)) begin
        next_p = replacement_r[8*((i + 1) % 8) +: 8];
      end
      if (emit) begin
        orig_nxt[i]    = (i + 1 < MAX_PATTERN) ? app_orig[(i + 1) % MAX_PATTERN] : '0;
        patched_nxt[i] = next_p;
      end else begin
        orig_nxt[i]    = app_orig[i];
        patched_nxt[i] = app_patched[i];
      end
    end

    out_nxt.out_byte    = (hit && rlen != '0) ? replacement_r[7:0] : app_patched[0];
    out_nxt.match_start = hit;
    out_nxt.out_last    = last_src && f_after == '0;

    fill_nxt  = op_go ? f_after : fill_r;
    busy_nxt  = op_go ? ((f_after >= plen) || (last_src && f_after != '0)) : busy_r;
    flush_nxt = op_go ? (last_src && f_after != '0) : flush_r;

    out_valid_nxt = emit ? 1'b1 : (out_stall ? out_valid_r : 1'b0);
    in_full_nxt   = (in_valid && !in_stall) ? 1'b1 : (consume ? 1'b0 : in_full_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_low_r  <= '0;
      pattern_high_r <= '0;
      pattern_len_r  <= wbp_pkg::PLEN_RST;
      replacement_r  <= '0;
      replace_len_r  <= '0;
      wildcard_r     <= wbp_pkg::WILDCARD_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        wbp_pkg::CFG_PATTERN_LOW:  pattern_low_r  <= cfg_wdata;
        wbp_pkg::CFG_PATTERN_HIGH: pattern_high_r <= cfg_wdata;
        wbp_pkg::CFG_PATTERN_LEN:  pattern_len_r  <= cfg_wdata[wbp_pkg::PLEN_W-1:0];
        wbp_pkg::CFG_REPLACEMENT:  replacement_r  <= cfg_wdata;
        wbp_pkg::CFG_REPLACE_LEN:  replace_len_r  <= cfg_wdata[wbp_pkg::RLEN_W-1:0];
        wbp_pkg::CFG_WILDCARD:     wildcard_r     <= cfg_wdata[wbp_pkg::BYTE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_full_r   <= 1'b0;
      fill_r      <= '0;
      busy_r      <= 1'b0;
      flush_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_full_r   <= in_full_nxt;
      fill_r      <= fill_nxt;
      busy_r      <= busy_nxt;
      flush_r     <= flush_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_r <= in_data;
    end
    if (op_go) begin
      orig_r    <= orig_nxt;
      patched_r <= patched_nxt;
    end
    if (emit) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_last_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && out_nxt.out_last) |=> (fill_r == '0 && !busy_r && !flush_r))
    else $error("window not empty after final byte of stream");

  a_flush_holds_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    flush_r |-> (busy_r && fill_r != '0))
    else $error("flush pending with empty window");

  a_drain_has_excess: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !flush_r) |-> (fill_r >= plen))
    else $error("drain without excess bytes");

endmodule
